// ===== design/deq_pkg.sv =====
// shared types and constants for the double-ended queue
// no dependencies; used by deq_ctrl, deq_dp and double_ended_queue_top
package deq_pkg;

    // default queue depth and word width
    localparam int DEQ_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    // command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_DUMP       = 3'd4
    } t_cmd_code;

    // result status codes carried on the output tuser
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    push_front;
        logic    push_rear;
        logic    pop_front;
        logic    pop_rear;
        logic    dump_start;
        logic    dump_next;
        logic    out_load;
        logic    out_from_mem;
        logic    out_last;
        t_status out_status;
    } t_dp_ctl;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/deq_ctrl.sv =====
// controller state machine for the double-ended queue
// depends on deq_pkg; drives deq_dp through t_dp_ctl
module deq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic [deq_pkg::CMD_W-1:0] i_req_cmd,
    output logic                   o_req_ready,
    input  deq_pkg::t_dp_stat      i_stat,
    output deq_pkg::t_dp_ctl       o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    // set while a pop is in flight, clear while a dump is
    logic   r_is_pop, n_is_pop;
    logic   w_accept;

    assign o_req_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept    = i_req_valid && o_req_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_is_pop = r_is_pop;
        o_ctl = '0;
        o_ctl.out_status = deq_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (deq_pkg::t_cmd_code'(i_req_cmd))
                        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_ctl.out_status = deq_pkg::ST_OVER;
                            end else if (i_req_cmd == deq_pkg::CMD_PUSH_FRONT) begin
                                o_ctl.push_front = 1'b1;
                            end else begin
                                o_ctl.push_rear = 1'b1;
                            end
                        end
                        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
                            if (i_stat.empty) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = deq_pkg::ST_UNDER;
                            end else begin
                                o_ctl.pop_front = (i_req_cmd == deq_pkg::CMD_POP_FRONT);
                                o_ctl.pop_rear  = (i_req_cmd == deq_pkg::CMD_POP_REAR);
                                n_is_pop = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        deq_pkg::CMD_DUMP: begin
                            if (i_stat.empty) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                o_ctl.dump_start = 1'b1;
                                n_is_pop = 1'b0;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            // unused codes are taken and dropped
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load     = 1'b1;
                    o_ctl.out_from_mem = 1'b1;
                    if (r_is_pop || i_stat.dump_last) begin
                        o_ctl.out_last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.dump_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_pop <= n_is_pop;
        end
    end

`ifndef SYNTHESIS
    // no new request is taken while a read is in flight
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_req_ready)
        else $error("request accepted during read");
    // a pop leaves the read state after one result
    a_pop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_is_pop && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("pop gave more than one result");
    // at most one queue command is issued to the datapath at a time
    a_read_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.pop_front, o_ctl.pop_rear, o_ctl.dump_start, o_ctl.dump_next,
                  o_ctl.push_front, o_ctl.push_rear}))
        else $error("conflicting datapath commands");
`endif

endmodule

// ===== design/deq_dp.sv =====
// datapath for the double-ended queue: entry memory, head and count, output register
// depends on deq_pkg; commanded by deq_ctrl
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  deq_pkg::t_dp_ctl              i_ctl,
    output deq_pkg::t_dp_stat             o_stat,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_out_value,
    output logic [deq_pkg::STAT_W-1:0]    o_out_status,
    output logic                          o_out_last
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [deq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]          r_head, n_head;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic                       r_out_valid;
    logic [ADDR_W-1:0]          w_addr;
    logic                       w_wr_en, w_rd_en;

    // place of an entry at an offset from the head, wrapped at the depth
    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] h,
                                               input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(h) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // status back to the controller
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.dump_last = (r_idx == r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // pointer updates and memory address
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        w_addr  = r_head;
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        if (i_ctl.push_front) begin
            n_head  = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
            w_addr  = n_head;
            w_wr_en = 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctl.push_rear) begin
            w_addr  = slot(r_head, r_count);
            w_wr_en = 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop_front) begin
            w_addr  = r_head;
            w_rd_en = 1'b1;
            n_head  = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_ctl.pop_rear) begin
            w_addr  = slot(r_head, r_count - 1'b1);
            w_rd_en = 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_ctl.dump_start) begin
            w_addr  = r_head;
            w_rd_en = 1'b1;
            n_idx   = CNT_W'(1);
        end else if (i_ctl.dump_next) begin
            w_addr  = slot(r_head, r_idx);
            w_rd_en = 1'b1;
            n_idx   = r_idx + 1'b1;
        end
    end

    // entry memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= i_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // head, count and dump position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_out_value  <= i_ctl.out_from_mem ? r_rd_data : '0;
            o_out_status <= i_ctl.out_status;
            o_out_last   <= i_ctl.out_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // count stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");
    // head stays inside the store
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W+1)'(r_head) < (CNT_W+1)'(DEPTH))
        else $error("head outside store");
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");
    // the queue is unchanged while a dump walks it
    a_dump_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.dump_next |=> (r_count == $past(r_count) && r_head == $past(r_head)))
        else $error("queue changed during dump");
`endif

endmodule

// ===== design/double_ended_queue_top.sv =====
// a push result is valid in the cycle after its request is taken; a pop result passes the
// registered memory read and then the output register, and no new request is taken while a
// pop or dump reads, set by the single registered read port of the entry memory
// reset (synchronous, active low) clears head, count, state and output valid;
// the entry memory is not cleared and needs no clearing pass
// top level of the double-ended queue; depends on deq_pkg, deq_ctrl and deq_dp
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // value[31:0]
    input  logic signed [deq_pkg::DATA_W-1:0] i_s_axis_tdata,
    // command[2:0]
    input  logic [deq_pkg::CMD_W-1:0]     i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // value_res[31:0]
    output logic signed [deq_pkg::DATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [deq_pkg::STAT_W-1:0]    o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);

    deq_pkg::t_dp_ctl  w_ctl;
    deq_pkg::t_dp_stat w_stat;

    // controller
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_cmd   (i_s_axis_tuser),
        .o_req_ready (o_s_axis_tready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    // datapath
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_stat       (w_stat),
        .i_value      (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_value  (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser),
        .o_out_last   (o_m_axis_tlast)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the double-ended queue: directed table, a receiver hold-off, then random bursts
// checks every result against an in-bench model of the queue, under idling and back-pressure
// depends on deq_pkg and double_ended_queue_top
module tb_top;

    localparam int DEPTH = deq_pkg::DEQ_DEPTH;
    typedef logic [deq_pkg::CMD_W-1:0] t_code;
    // command codes the block ignores
    localparam t_code CMD_RSV_FIRST = 3'd5;
    localparam t_code CMD_RSV_MID   = 3'd6;
    localparam t_code CMD_RSV_LAST  = 3'd7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_REQUESTS  = 60;

    // one result as the block should give it
    typedef struct packed {
        logic signed [deq_pkg::DATA_W-1:0] word;
        deq_pkg::t_status                  st;
        logic                              last;
    } t_result;

    // one row of the directed table
    typedef struct packed {
        logic [deq_pkg::CMD_W-1:0]         code;
        logic signed [deq_pkg::DATA_W-1:0] word;
        logic                              typed;
        t_result                           res;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    // value[31:0]
    logic signed [deq_pkg::DATA_W-1:0] i_s_axis_tdata;
    // command[2:0]
    logic [deq_pkg::CMD_W-1:0]         i_s_axis_tuser;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    // value_res[31:0]
    logic signed [deq_pkg::DATA_W-1:0] o_m_axis_tdata;
    // status[1:0]
    logic [deq_pkg::STAT_W-1:0]        o_m_axis_tuser;
    logic                              o_m_axis_tlast;

    double_ended_queue_top #(.DEPTH(DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // mirror of the queue contents
    logic signed [deq_pkg::DATA_W-1:0] mirror_store [DEPTH];
    int unsigned              mirror_head;
    int unsigned              mirror_fill;
    t_result                  pending_results [$];
    int                       last_added;

    // run control and counters
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_cycles;
    int n_errors;
    int n_requests;
    int n_ignored;
    int n_checked;
    int n_overflow;
    int n_underflow;
    int n_empty_dump;
    int peak_fill;

    // directed rows: typed results only for empty pops, empty dumps and extreme words
    localparam int DIR_ROWS = 25;
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{deq_pkg::CMD_POP_FRONT,  32'sh1234_5678, 1'b1, '{32'sd0, deq_pkg::ST_UNDER, 1'b1}},
        '{deq_pkg::CMD_POP_REAR,   32'sh7FFF_FFFF, 1'b1, '{32'sd0, deq_pkg::ST_UNDER, 1'b1}},
        '{deq_pkg::CMD_DUMP,       32'shFFFF_FFFF, 1'b1, '{32'sd0, deq_pkg::ST_EMPTY, 1'b1}},
        '{CMD_RSV_FIRST,           32'sh0BAD_0BAD, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1, '{32'sd0, deq_pkg::ST_OK,    1'b1}},
        '{deq_pkg::CMD_PUSH_REAR,  32'sh8000_0000, 1'b1, '{32'sd0, deq_pkg::ST_OK,    1'b1}},
        '{deq_pkg::CMD_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, '{32'sd0, deq_pkg::ST_OK,    1'b1}},
        '{deq_pkg::CMD_PUSH_REAR,  32'sh0000_0000, 1'b1, '{32'sd0, deq_pkg::ST_OK,    1'b1}},
        '{deq_pkg::CMD_DUMP,       32'sh5555_5555, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{CMD_RSV_MID,             32'shAAAA_AAAA, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_POP_FRONT,  32'sh0F0F_0F0F, 1'b1,
          '{32'shFFFF_FFFF, deq_pkg::ST_OK, 1'b1}},
        '{deq_pkg::CMD_POP_REAR,   32'shF0F0_F0F0, 1'b1,
          '{32'sh0000_0000, deq_pkg::ST_OK, 1'b1}},
        '{CMD_RSV_LAST,            32'sh0000_0001, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_DUMP,       32'sh0000_0000, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_POP_REAR,   32'sh3C3C_3C3C, 1'b1,
          '{32'sh8000_0000, deq_pkg::ST_OK, 1'b1}},
        '{deq_pkg::CMD_POP_FRONT,  32'shC3C3_C3C3, 1'b1,
          '{32'sh7FFF_FFFF, deq_pkg::ST_OK, 1'b1}},
        '{deq_pkg::CMD_POP_FRONT,  32'sh8000_0000, 1'b1, '{32'sd0, deq_pkg::ST_UNDER, 1'b1}},
        '{deq_pkg::CMD_PUSH_REAR,  32'sh5A5A_5A5A, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_PUSH_REAR,  32'shA5A5_A5A5, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_POP_FRONT,  32'sh0000_0000, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_PUSH_FRONT, 32'sh1234_5678, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_DUMP,       32'sh1111_1111, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_POP_REAR,   32'sh2222_2222, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_POP_REAR,   32'sh3333_3333, 1'b0, '{32'sd0, deq_pkg::ST_OK,    1'b0}},
        '{deq_pkg::CMD_DUMP,       32'sh4444_4444, 1'b1, '{32'sd0, deq_pkg::ST_EMPTY, 1'b1}}
    };

    // queue the results one request should give and update the mirror
    function automatic void deque_predict(input logic [deq_pkg::CMD_W-1:0] code,
                                          input logic signed [deq_pkg::DATA_W-1:0] word);
        int unsigned slot;
        int unsigned i;
        last_added = 1;
        case (code)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
                if (mirror_fill >= DEPTH) begin
                    pending_results.push_back('{32'sd0, deq_pkg::ST_OVER, 1'b1});
                    n_overflow++;
                end else begin
                    if (code == deq_pkg::CMD_PUSH_FRONT) begin
                        mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                        slot = mirror_head;
                    end else begin
                        slot = (mirror_head + mirror_fill) % DEPTH;
                    end
                    mirror_store[slot] = word;
                    mirror_fill++;
                    if (mirror_fill > peak_fill) peak_fill = mirror_fill;
                    pending_results.push_back('{32'sd0, deq_pkg::ST_OK, 1'b1});
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
                if (mirror_fill == 0) begin
                    pending_results.push_back('{32'sd0, deq_pkg::ST_UNDER, 1'b1});
                    n_underflow++;
                end else begin
                    if (code == deq_pkg::CMD_POP_FRONT) begin
                        slot = mirror_head;
                        mirror_head = (mirror_head + 1) % DEPTH;
                    end else begin
                        slot = (mirror_head + mirror_fill - 1) % DEPTH;
                    end
                    mirror_fill--;
                    pending_results.push_back('{mirror_store[slot], deq_pkg::ST_OK, 1'b1});
                end
            end
            deq_pkg::CMD_DUMP: begin
                if (mirror_fill == 0) begin
                    pending_results.push_back('{32'sd0, deq_pkg::ST_EMPTY, 1'b1});
                    n_empty_dump++;
                end else begin
                    for (i = 0; i < mirror_fill; i++) begin
                        slot = (mirror_head + i) % DEPTH;
                        pending_results.push_back('{mirror_store[slot], deq_pkg::ST_OK,
                                                    (i + 1 == mirror_fill)});
                    end
                    last_added = mirror_fill;
                end
            end
            default: last_added = 0;
        endcase
    endfunction

    // data word, often an extreme
    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // offer one request, wait for acceptance, then predict its results
    task automatic send_request(input logic [deq_pkg::CMD_W-1:0] code,
                                input logic signed [deq_pkg::DATA_W-1:0] word);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= code;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        deque_predict(code, word);
        if (code >= CMD_RSV_FIRST) n_ignored++;
        else n_requests++;
    endtask

    // stop offering until every expected result is out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // pushes up to full with an occasional dump, then pushes that overflow and maybe a dump
    task automatic fill_burst();
        while (mirror_fill < DEPTH) begin
            if ($urandom_range(19) == 0) send_request(deq_pkg::CMD_DUMP, pick_word());
            else send_request($urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT
                                                : deq_pkg::CMD_PUSH_REAR, pick_word());
        end
        repeat ($urandom_range(1, 2))
            send_request($urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT
                                           : deq_pkg::CMD_PUSH_REAR, pick_word());
        if ($urandom_range(1)) send_request(deq_pkg::CMD_DUMP, pick_word());
    endtask

    // pops down to empty, then pops that underflow and an empty dump
    task automatic drain_burst();
        while (mirror_fill != 0)
            send_request($urandom_range(1) ? deq_pkg::CMD_POP_FRONT
                                           : deq_pkg::CMD_POP_REAR, pick_word());
        repeat ($urandom_range(1, 2))
            send_request($urandom_range(1) ? deq_pkg::CMD_POP_FRONT
                                           : deq_pkg::CMD_POP_REAR, pick_word());
        send_request(deq_pkg::CMD_DUMP, pick_word());
    endtask

    // any command, a few ignored codes among them
    task automatic mixed_burst(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 20)      send_request(deq_pkg::CMD_PUSH_FRONT, pick_word());
            else if (r < 40) send_request(deq_pkg::CMD_PUSH_REAR, pick_word());
            else if (r < 62) send_request(deq_pkg::CMD_POP_FRONT, pick_word());
            else if (r < 84) send_request(deq_pkg::CMD_POP_REAR, pick_word());
            else if (r < 96) send_request(deq_pkg::CMD_DUMP, pick_word());
            else send_request(t_code'($urandom_range(CMD_RSV_FIRST, CMD_RSV_LAST)),
                              pick_word());
        end
    endtask

    // one idling setting, random bursts until enough requests went in
    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int target;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target = n_requests + n_items;
        while (n_requests < target) begin
            case ($urandom_range(3))
                0:       fill_burst();
                1:       drain_burst();
                default: mixed_burst(16 + $urandom_range(16));
            endcase
        end
        wait_drained();
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // result checker
    initial begin
        t_result exp_res;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result value_res=%h status=%0d last=%0b",
                             $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    n_errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    n_checked++;
                    if (o_m_axis_tdata !== exp_res.word || o_m_axis_tuser !== exp_res.st ||
                        o_m_axis_tlast !== exp_res.last) begin
                        $display("%0t: mismatch expected value_res=%h status=%0d last=%0b",
                                 $time, exp_res.word, exp_res.st, exp_res.last);
                        $display("%0t:          actual   value_res=%h status=%0d last=%0b",
                                 $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                        n_errors++;
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results still expected", $time,
                 pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // main sequence
    initial begin
        int k;
        i_rst_n            <= 1'b0;
        i_s_axis_tvalid    <= 1'b0;
        i_s_axis_tdata     <= '0;
        i_s_axis_tuser     <= '0;
        i_m_axis_tready    <= 1'b0;
        mirror_head        = 0;
        mirror_fill        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 0;
        n_errors           = 0;
        n_requests         = 0;
        n_ignored          = 0;
        n_checked          = 0;
        n_overflow         = 0;
        n_underflow        = 0;
        n_empty_dump       = 0;
        peak_fill          = 0;
        last_added         = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (k = 0; k < DIR_ROWS; k++) begin
            send_request(dir_tab[k].code, dir_tab[k].word);
            if (dir_tab[k].typed) begin
                repeat (last_added) void'(pending_results.pop_back());
                pending_results.push_back(dir_tab[k].res);
            end
        end
        wait_drained();

        // receiver held off while the sender keeps pushing, so the input stalls
        hold_cycles = HOLD_OFF_CYCLES;
        fill_burst();
        wait_drained();

        // random phases with different idling
        run_phase(0, 0, PHASE_REQUESTS);
        run_phase(61, 0, PHASE_REQUESTS);
        run_phase(0, 61, PHASE_REQUESTS);
        run_phase(16, 16, PHASE_REQUESTS);
        repeat (16) @(posedge i_clk);

        $display("covered %0d requests and %0d ignored codes, %0d results checked",
                 n_requests, n_ignored, n_checked);
        $display("overflows %0d, underflows %0d, empty dumps %0d, peak fill %0d of %0d",
                 n_overflow, n_underflow, n_empty_dump, peak_fill, DEPTH);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
